// ----- hw/rtl/indexed_list_insert_delete_defines.svh -----
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check prop at every clock edge outside reset.
`define ILD_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define ILD_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define ILD_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define ILD_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif

`endif

// ----- hw/rtl/ild_pkg.sv -----
package ild_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned OP_W             = 3;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned DEFAULT_CAPACITY = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         count_out;
  } rsp_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // open a slot at pos, shift upper cells up
    logic del;    // close the slot at pos, shift upper cells down
    logic snap;   // copy each element into the read chain
    logic shift;  // move the read chain one cell toward cell 0
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/indexed_list_insert_delete.sv -----
// Channel  Signals                      Direction  Word
// req      req_valid, req_ready, req    in         op, position, value_in
// rsp      rsp_valid, rsp_ready, rsp    out        status, value_out, count_out
//
// Insert, delete, failed requests: the result word is registered and appears in the cycle after the request is taken.
// Read at position p: the read chain shifts one cell per cycle until entry p reaches cell 0.
// A new request is taken only in idle, when the result register is free or drains.
// Reset clears the count, state and result valid and holds req_ready low;
// element cells are not reset.
// A stalled rsp holds its word; the block waits without losing it.
`include "indexed_list_insert_delete_defines.svh"

module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ild_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ild_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ild_pkg::rsp_t rsp
);
  import ild_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  // Element chain: elem[i] is list entry i, rd[] is the read shift line.
  logic signed [DATA_W-1:0] elem [CAPACITY];
  logic signed [DATA_W-1:0] rd   [CAPACITY];

  state_e        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_cnt;
  cell_ctrl_t    ctrl;

  logic          accept;
  logic          slot_free;
  logic          is_ins, is_del, is_read;
  logic          req_ok;
  logic [PW-1:0] count_ext;
  logic [PW-1:0] eff_pos;
  logic [PW-1:0] new_count;
  status_e       status;
  logic          load_now;
  logic          load_scan;

  assign count_ext = PW'(count);
  assign slot_free = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // Decode the request and pick the effective position.
  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_read = 1'b0;
    eff_pos = PW'(req.position);
    unique case (req.op)
      OP_INS_FRONT: begin
        is_ins  = 1'b1;
        eff_pos = '0;
      end
      OP_INS_BACK: begin
        is_ins  = 1'b1;
        eff_pos = count_ext;
      end
      OP_INS_AT: is_ins = 1'b1;
      OP_DEL_FRONT: begin
        is_del  = 1'b1;
        eff_pos = '0;
      end
      OP_DEL_BACK: begin
        is_del  = 1'b1;
        eff_pos = count_ext - PW'(1);
      end
      OP_DEL_AT: is_del  = 1'b1;
      OP_READ:   is_read = 1'b1;
      default: ;
    endcase
  end

  // Full wins over a bad position; an empty list fails every delete and read position.
  always_comb begin
    status = STATUS_BAD;
    if (is_ins) begin
      if (count == CW'(CAPACITY)) begin
        status = STATUS_FULL;
      end else if (eff_pos <= count_ext) begin
        status = STATUS_OK;
      end
    end else if (is_del || is_read) begin
      if (eff_pos < count_ext) begin
        status = STATUS_OK;
      end
    end
  end

  assign req_ok = (status == STATUS_OK);

  always_comb begin
    new_count = count_ext;
    if (req_ok && is_ins) begin
      new_count = count_ext + PW'(1);
    end else if (req_ok && is_del) begin
      new_count = count_ext - PW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_read && req_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0 && slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    req_ready  = 1'b0;
    ctrl       = '0;
    load_now   = 1'b0;
    load_scan  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = slot_free && !rst;
        ctrl.ins  = accept && is_ins && req_ok;
        ctrl.del  = accept && is_del && req_ok;
        ctrl.snap = accept && is_read && req_ok;
        load_now  = accept && !(is_read && req_ok);
      end
      ST_SCAN: begin
        ctrl.shift = (scan_cnt != '0);
        load_scan  = (scan_cnt == '0) && slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctrl.ins || ctrl.del) begin
        count <= new_count[CW-1:0];
      end
    end
  end

  // Hold the distance still to travel down the read chain.
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      scan_cnt <= eff_pos[CW-1:0];
    end else if (ctrl.shift) begin
      scan_cnt <= scan_cnt - CW'(1);
    end
  end

  // Result register: parts the request side from the response side.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_now || load_scan) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      rsp.status    <= status;
      rsp.value_out <= '0;
      rsp.count_out <= new_count[POS_W-1:0];
    end else if (load_scan) begin
      rsp.status    <= STATUS_OK;
      rsp.value_out <= rd[0];
      rsp.count_out <= count_ext[POS_W-1:0];
    end
  end

  // Chain of element cells; each trades with its neighbors on insert, delete and read shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_elem, right_elem, right_rd;

    if (i == 0) begin : g_first
      assign left_elem = req.value_in;
    end else begin : g_mid
      assign left_elem = elem[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_elem = '0;
      assign right_rd   = '0;
    end else begin : g_body
      assign right_elem = elem[i+1];
      assign right_rd   = rd[i+1];
    end

    ild_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (eff_pos),
      .value_in   (req.value_in),
      .left_elem  (left_elem),
      .right_elem (right_elem),
      .right_rd   (right_rd),
      .elem       (elem[i]),
      .rd         (rd[i])
    );
  end

  `ILD_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count above capacity")
  `ILD_ASSERT_ALWAYS(a_no_req_in_scan, clk, (state == ST_SCAN) |-> !req_ready, "ready in scan")
  `ILD_ASSERT(a_scan_step, clk, rst, ctrl.shift |=> scan_cnt == $past(scan_cnt) - CW'(1), "stuck")
  `ILD_ASSERT(a_read_enters_scan, clk, rst, ctrl.snap |=> state == ST_SCAN, "read not in scan")

endmodule

// ----- hw/rtl/ild_cell.sv -----
module ild_cell #(
  parameter int unsigned CAPACITY = ild_pkg::DEFAULT_CAPACITY,
  parameter int unsigned IDX      = 0,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned PW = (CW > ild_pkg::POS_W) ? CW : ild_pkg::POS_W
) (
  input  logic                               clk,
  input  ild_pkg::cell_ctrl_t                ctrl,
  input  logic [PW-1:0]                      pos,
  input  logic signed [ild_pkg::DATA_W-1:0]  value_in,
  input  logic signed [ild_pkg::DATA_W-1:0]  left_elem,
  input  logic signed [ild_pkg::DATA_W-1:0]  right_elem,
  input  logic signed [ild_pkg::DATA_W-1:0]  right_rd,
  output logic signed [ild_pkg::DATA_W-1:0]  elem,
  output logic signed [ild_pkg::DATA_W-1:0]  rd
);
  import ild_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX > pos) begin
        elem <= left_elem;
      end else if (MY_IDX == pos) begin
        elem <= value_in;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= pos) begin
        elem <= right_elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      rd <= elem;
    end else if (ctrl.shift) begin
      rd <= right_rd;
    end
  end

endmodule
